// File: src/bmp24_pkg.sv
`timescale 1ns / 1ps

package bmp24_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int DIM_W  = 16;
    localparam int POS_W  = 32;
    localparam int ADDR_W = 14;

    localparam logic [POS_W-1:0] HDR_END = POS_W'(26);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_PIXELS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_DIM    = 2'd1,
        STATUS_BAD_OFFSET = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } byte_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic [7:0]        pixel_byte;
        logic              last_byte;
        logic [1:0]        status;
    } pixel_beat_t;

endpackage

// File: src/bmp24_stream_pixel_unpacker.sv
`timescale 1ns / 1ps

// Channel | Valid       | Stall       | Payload
// input   | byte_valid  | byte_stall  | byte_data  (bmp24_pkg::byte_beat_t)
// output  | pixel_valid | pixel_stall | pixel_data (bmp24_pkg::pixel_beat_t)
//
// Each file byte waits in the input register and then moves on to the
// result register, from which its pixel beat is offered.
// One byte is taken every cycle while the output is not stalled.
// Reset clears the parser to the header phase; the first byte after reset
// counts as file byte 0 even without start_of_file.
// A stalled output holds its beat, and one more byte may still enter the
// input register before byte_stall rises.

module bmp24_stream_pixel_unpacker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  bmp24_pkg::byte_beat_t  byte_data,
    output logic                   pixel_valid,
    input  logic                   pixel_stall,
    output bmp24_pkg::pixel_beat_t pixel_data
);

    localparam int COL_W  = bmp24_pkg::COL_W;
    localparam int ROW_W  = bmp24_pkg::ROW_W;
    localparam int DIM_W  = bmp24_pkg::DIM_W;
    localparam int POS_W  = bmp24_pkg::POS_W;
    localparam int ADDR_W = bmp24_pkg::ADDR_W;

    logic                   in_valid_reg, in_valid_next;
    bmp24_pkg::byte_beat_t  in_data_reg, in_data_next;
    logic                   out_valid_reg, out_valid_next;
    bmp24_pkg::pixel_beat_t out_data_reg, out_data_next;

    bmp24_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]       offset_reg, offset_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic              width_big_reg, width_big_next;
    logic              height_big_reg, height_big_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [1:0]        chan_reg, chan_next;
    logic [1:0]        pad_reg, pad_next;

    bmp24_pkg::phase_t cur_phase;
    logic [POS_W-1:0]  cur_pos;
    logic [31:0]       cur_offset;
    logic [DIM_W-1:0]  cur_width, cur_height;
    logic              cur_width_big, cur_height_big;
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [1:0]        cur_chan, cur_pad;

    logic              advance;
    logic [7:0]        b;
    logic [POS_W-1:0]  pos_inc;
    logic              hdr_end, bad_dim, bad_offset, is_last, pixel_out;
    logic [COL_W-1:0]  col_inc, w_col;
    logic [ROW_W-1:0]  row_inc, h_row, frame_row;
    logic [ADDR_W-1:0] linear, addr;

    assign advance    = in_valid_reg && (!out_valid_reg || !pixel_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign pixel_valid = out_valid_reg;
    assign pixel_data  = out_data_reg;
    assign b = in_data_reg.file_byte;

    // A start mark restarts the parse from the reset state on this byte.
    always_comb
    begin
        if (in_data_reg.start_of_file)
        begin
            cur_phase      = bmp24_pkg::PH_HEADER;
            cur_pos        = '0;
            cur_offset     = '0;
            cur_width      = '0;
            cur_height     = '0;
            cur_width_big  = 1'b0;
            cur_height_big = 1'b0;
            cur_col        = '0;
            cur_row        = '0;
            cur_chan       = '0;
            cur_pad        = '0;
        end
        else
        begin
            cur_phase      = phase_reg;
            cur_pos        = pos_reg;
            cur_offset     = offset_reg;
            cur_width      = width_reg;
            cur_height     = height_reg;
            cur_width_big  = width_big_reg;
            cur_height_big = height_big_reg;
            cur_col        = col_reg;
            cur_row        = row_reg;
            cur_chan       = chan_reg;
            cur_pad        = pad_reg;
        end
    end

    // Header field capture; the height is complete on the same byte that
    // triggers the header check.
    always_comb
    begin
        offset_next     = cur_offset;
        width_next      = cur_width;
        height_next     = cur_height;
        width_big_next  = cur_width_big;
        height_big_next = cur_height_big;
        if (cur_phase == bmp24_pkg::PH_HEADER)
        begin
            unique case (cur_pos[4:0])
                5'd10: offset_next[7:0]    = b;
                5'd11: offset_next[15:8]   = b;
                5'd12: offset_next[23:16]  = b;
                5'd13: offset_next[31:24]  = b;
                5'd18: width_next[7:0]     = b;
                5'd19: width_next[15:8]    = b;
                5'd20: width_big_next      = cur_width_big || (b != 8'd0);
                5'd21: width_big_next      = cur_width_big || (b != 8'd0);
                5'd22: height_next[7:0]    = b;
                5'd23: height_next[15:8]   = b;
                5'd24: height_big_next     = cur_height_big || (b != 8'd0);
                5'd25: height_big_next     = cur_height_big || (b != 8'd0);
                default: ;
            endcase
        end
    end

    assign pos_inc = cur_pos + POS_W'(1);
    assign hdr_end = (pos_inc == bmp24_pkg::HDR_END);
    assign bad_dim = width_big_next || (width_next == '0)
                     || (width_next > DIM_W'(bmp24_pkg::MAX_WIDTH))
                     || height_big_next || (height_next == '0)
                     || (height_next > DIM_W'(bmp24_pkg::MAX_HEIGHT));
    assign bad_offset = (offset_next < 32'(bmp24_pkg::HDR_END));

    assign w_col     = cur_width[COL_W-1:0];
    assign h_row     = cur_height[ROW_W-1:0];
    assign col_inc   = cur_col + COL_W'(1);
    assign row_inc   = cur_row + ROW_W'(1);
    assign frame_row = h_row - ROW_W'(1) - cur_row;
    assign linear    = ADDR_W'(cur_col) + ADDR_W'(frame_row) * ADDR_W'(w_col);
    assign addr      = ADDR_W'(linear + (linear << 1)) + ADDR_W'(cur_chan);
    assign is_last   = (row_inc == h_row) && (col_inc == w_col) && (cur_chan == 2'd2);
    assign pixel_out = (cur_phase == bmp24_pkg::PH_PIXELS) && (cur_pad == 2'd0);

    always_comb
    begin
        phase_next = cur_phase;
        unique case (cur_phase)
            bmp24_pkg::PH_HEADER:
            begin
                if (hdr_end)
                begin
                    if (bad_dim || bad_offset)
                        phase_next = bmp24_pkg::PH_DONE;
                    else if (offset_next == 32'(bmp24_pkg::HDR_END))
                        phase_next = bmp24_pkg::PH_PIXELS;
                    else
                        phase_next = bmp24_pkg::PH_SKIP;
                end
            end
            bmp24_pkg::PH_SKIP:
            begin
                if (pos_inc == offset_next)
                    phase_next = bmp24_pkg::PH_PIXELS;
            end
            bmp24_pkg::PH_PIXELS:
            begin
                if (pixel_out && is_last)
                    phase_next = bmp24_pkg::PH_DONE;
            end
            bmp24_pkg::PH_DONE: ;
            default: ;
        endcase
    end

    always_comb
    begin
        pos_next  = cur_pos;
        col_next  = cur_col;
        row_next  = cur_row;
        chan_next = cur_chan;
        pad_next  = cur_pad;
        if (cur_phase == bmp24_pkg::PH_HEADER || cur_phase == bmp24_pkg::PH_SKIP)
            pos_next = pos_inc;
        if (cur_phase == bmp24_pkg::PH_PIXELS)
        begin
            if (cur_pad != 2'd0)
                pad_next = cur_pad - 2'd1;
            else if (cur_chan == 2'd2)
            begin
                chan_next = 2'd0;
                if (col_inc == w_col)
                begin
                    col_next = '0;
                    row_next = row_inc;
                    pad_next = cur_width[1:0];
                end
                else
                    col_next = col_inc;
            end
            else
                chan_next = cur_chan + 2'd1;
        end
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && pixel_stall;
        if (advance)
        begin
            out_valid_next = 1'b0;
            if (cur_phase == bmp24_pkg::PH_HEADER && hdr_end && (bad_dim || bad_offset))
            begin
                out_valid_next              = 1'b1;
                out_data_next.frame_address = '0;
                out_data_next.pixel_byte    = '0;
                out_data_next.last_byte     = 1'b0;
                out_data_next.status        = bad_dim ? bmp24_pkg::STATUS_BAD_DIM
                                                      : bmp24_pkg::STATUS_BAD_OFFSET;
            end
            else if (pixel_out)
            begin
                out_valid_next              = 1'b1;
                out_data_next.frame_address = addr;
                out_data_next.pixel_byte    = b;
                out_data_next.last_byte     = is_last;
                out_data_next.status        = bmp24_pkg::STATUS_OK;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg && !advance;
        in_data_next  = in_data_reg;
        if (byte_valid && !byte_stall)
        begin
            in_valid_next = 1'b1;
            in_data_next  = byte_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= bmp24_pkg::PH_HEADER;
            pos_reg        <= '0;
            offset_reg     <= '0;
            width_reg      <= '0;
            height_reg     <= '0;
            width_big_reg  <= 1'b0;
            height_big_reg <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            chan_reg       <= '0;
            pad_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                offset_reg     <= offset_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                width_big_reg  <= width_big_next;
                height_big_reg <= height_big_next;
                col_reg        <= col_next;
                row_reg        <= row_next;
                chan_reg       <= chan_next;
                pad_reg        <= pad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: tb/sv/bmp24_stream_pixel_unpacker_tb.sv
`timescale 1ns / 1ps

module bmp24_stream_pixel_unpacker_tb;

    typedef struct {
        bmp24_pkg::byte_beat_t beat;
        bit                    drain_first;
    } file_item_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } stall_mode_t;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_BYTES  = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   byte_valid = 1'b0;
    logic                   byte_stall;
    bmp24_pkg::byte_beat_t  byte_data = '0;
    logic                   pixel_valid;
    logic                   pixel_stall = 1'b0;
    bmp24_pkg::pixel_beat_t pixel_data;

    file_item_t             file_bytes[$];
    bmp24_pkg::pixel_beat_t pending_pixels[$];

    // Shadow of the unpacker state.
    bmp24_pkg::phase_t parser_phase;
    logic [31:0] file_pos;
    logic [31:0] pix_offset;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [31:0] chan_cnt;
    logic [31:0] pad_cnt;

    logic                   beat_accepted = 1'b0;
    logic                   hold_out = 1'b0;
    int                     pixels_seen = 0;
    int                     errors_found = 0;
    int                     burst_left = 0;
    int                     gap_left = 0;
    file_item_t             next_item;
    stall_mode_t            stall_mode = STALL_NONE;
    int                     mode_left = 0;
    int                     stall_tick = 0;
    logic                   stall_now;
    bmp24_pkg::pixel_beat_t want;
    bmp24_pkg::pixel_beat_t predicted;

    bmp24_stream_pixel_unpacker dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_data   (byte_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_data  (pixel_data)
    );

    always #4 clk = ~clk;

    function automatic void clear_parser();
        parser_phase = bmp24_pkg::PH_HEADER;
        file_pos     = '0;
        pix_offset   = '0;
        img_width    = '0;
        img_height   = '0;
        col_cnt      = '0;
        row_cnt      = '0;
        chan_cnt     = '0;
        pad_cnt      = '0;
    endfunction

    function automatic bit unpack_byte(input bmp24_pkg::byte_beat_t beat,
                                       output bmp24_pkg::pixel_beat_t res);
        logic [31:0] at;
        logic [31:0] wide_byte;
        logic [31:0] frame_row;
        logic [31:0] addr;
        logic        last;
        bit          emitted;
        res = '0;
        emitted = 1'b0;
        if (beat.start_of_file)
            clear_parser();
        at = file_pos;
        wide_byte = {24'd0, beat.file_byte};
        case (parser_phase)
            bmp24_pkg::PH_HEADER:
            begin
                file_pos = at + 1;
                if (at >= 10 && at <= 13)
                    pix_offset = pix_offset | (wide_byte << (8 * (at - 10)));
                else if (at >= 18 && at <= 21)
                    img_width = img_width | (wide_byte << (8 * (at - 18)));
                else if (at >= 22 && at <= 25)
                    img_height = img_height | (wide_byte << (8 * (at - 22)));
                if (at + 1 == bmp24_pkg::HDR_END)
                begin
                    if (img_width == 0 || img_width > bmp24_pkg::MAX_WIDTH ||
                        img_height == 0 || img_height > bmp24_pkg::MAX_HEIGHT)
                    begin
                        parser_phase = bmp24_pkg::PH_DONE;
                        res.status = bmp24_pkg::STATUS_BAD_DIM;
                        emitted = 1'b1;
                    end
                    else if (pix_offset < bmp24_pkg::HDR_END)
                    begin
                        parser_phase = bmp24_pkg::PH_DONE;
                        res.status = bmp24_pkg::STATUS_BAD_OFFSET;
                        emitted = 1'b1;
                    end
                    else
                    begin
                        parser_phase = (pix_offset == bmp24_pkg::HDR_END)
                                       ? bmp24_pkg::PH_PIXELS : bmp24_pkg::PH_SKIP;
                    end
                end
            end
            bmp24_pkg::PH_SKIP:
            begin
                file_pos = at + 1;
                if (at + 1 == pix_offset)
                    parser_phase = bmp24_pkg::PH_PIXELS;
            end
            bmp24_pkg::PH_PIXELS:
            begin
                if (pad_cnt != 0)
                begin
                    pad_cnt = pad_cnt - 1;
                end
                else
                begin
                    frame_row = img_height - 1 - row_cnt;
                    addr = 3 * (col_cnt + frame_row * img_width) + chan_cnt;
                    last = (row_cnt + 1 == img_height && col_cnt + 1 == img_width &&
                            chan_cnt == 2);
                    res.frame_address = addr[bmp24_pkg::ADDR_W-1:0];
                    res.pixel_byte    = beat.file_byte;
                    res.last_byte     = last;
                    res.status        = bmp24_pkg::STATUS_OK;
                    emitted = 1'b1;
                    if (chan_cnt == 2)
                    begin
                        chan_cnt = 0;
                        col_cnt = col_cnt + 1;
                        if (col_cnt == img_width)
                        begin
                            col_cnt = 0;
                            row_cnt = row_cnt + 1;
                            pad_cnt = img_width & 32'd3;
                        end
                    end
                    else
                    begin
                        chan_cnt = chan_cnt + 1;
                    end
                    if (last)
                        parser_phase = bmp24_pkg::PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
        return emitted;
    endfunction

    // Queues one file: the 26 header bytes, then the skip and pixel region
    // lengthened or cut short by extra bytes.
    task automatic queue_file(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] off, input bit mark,
                              input bit drain, input int extra);
        file_item_t item;
        longint     body;
        logic [7:0] b;
        body = 0;
        if (w >= 1 && w <= bmp24_pkg::MAX_WIDTH && h >= 1 && h <= bmp24_pkg::MAX_HEIGHT &&
            off >= 26 && off <= 26 + 4096)
            body = longint'(off) - 26 + longint'(h) * (3 * longint'(w) + longint'(w & 3));
        body = body + extra;
        for (int k = 0; k < 26; k++)
        begin
            if (k >= 10 && k <= 13)
                b = 8'(off >> (8 * (k - 10)));
            else if (k >= 18 && k <= 21)
                b = 8'(w >> (8 * (k - 18)));
            else if (k >= 22 && k <= 25)
                b = 8'(h >> (8 * (k - 22)));
            else
                b = 8'($urandom());
            item.beat.file_byte = b;
            item.beat.start_of_file = (k == 0) && mark;
            item.drain_first = (k == 0) && drain;
            file_bytes.push_back(item);
        end
        for (longint k = 0; k < body; k++)
        begin
            item.beat.file_byte = 8'($urandom());
            item.beat.start_of_file = 1'b0;
            item.drain_first = 1'b0;
            file_bytes.push_back(item);
        end
    endtask

    function automatic logic [31:0] small_dim();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    endfunction

    function automatic logic [31:0] bad_dim();
        case ($urandom_range(0, 2))
            0: return 32'd0;
            1: return 32'd65 + $urandom_range(0, 62);
            default: return $urandom() | 32'h80;
        endcase
    endfunction

    // Driver: one beat per handshake, bursts with random gaps in between.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else if (!byte_valid || beat_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                byte_valid <= 1'b0;
            end
            else if (file_bytes.size() == 0 ||
                     (file_bytes[0].drain_first && pending_pixels.size() != 0))
            begin
                byte_valid <= 1'b0;
            end
            else
            begin
                next_item = file_bytes.pop_front();
                byte_data <= next_item.beat;
                byte_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                end
                else
                begin
                    burst_left = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                                      : $urandom_range(20, 80);
                    gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
        end
        else
        begin
            mode_left = mode_left - 1;
        end
        stall_tick = stall_tick + 1;
        case (stall_mode)
            STALL_LIGHT:       stall_now = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:       stall_now = ($urandom_range(0, 3) != 0);
            STALL_EVERY_THIRD: stall_now = (stall_tick % 3 == 0);
            default:           stall_now = 1'b0;
        endcase
        pixel_stall <= stall_now || hold_out;
    end

    // Monitor: results are checked before the byte taken at the same edge
    // is predicted, since a byte never shows up at its own edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            beat_accepted <= 1'b0;
            clear_parser();
        end
        else
        begin
            beat_accepted <= byte_valid && !byte_stall;
            if (pixel_valid && !pixel_stall)
            begin
                pixels_seen = pixels_seen + 1;
                if (pending_pixels.size() == 0)
                begin
                    $error("unexpected pixel beat: frame_address %0d pixel_byte %0d",
                           pixel_data.frame_address, pixel_data.pixel_byte);
                    errors_found = errors_found + 1;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_data.frame_address !== want.frame_address)
                    begin
                        $error("frame_address: expected %0d, got %0d",
                               want.frame_address, pixel_data.frame_address);
                        errors_found = errors_found + 1;
                    end
                    if (pixel_data.pixel_byte !== want.pixel_byte)
                    begin
                        $error("pixel_byte: expected %0d, got %0d",
                               want.pixel_byte, pixel_data.pixel_byte);
                        errors_found = errors_found + 1;
                    end
                    if (pixel_data.last_byte !== want.last_byte)
                    begin
                        $error("last_byte: expected %0d, got %0d",
                               want.last_byte, pixel_data.last_byte);
                        errors_found = errors_found + 1;
                    end
                    if (pixel_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, pixel_data.status);
                        errors_found = errors_found + 1;
                    end
                end
            end
            if (byte_valid && !byte_stall)
            begin
                if (unpack_byte(byte_data, predicted))
                    pending_pixels.push_back(predicted);
            end
        end
    end

    // Long receiver hold-off while the sender keeps going, so the input backs up.
    initial
    begin
        while (pixels_seen < 40)
            @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int kind;
        int directed_len;
        int noise;
        file_item_t item;
        logic [31:0] w;
        logic [31:0] h;

        // The first file after reset carries no start mark.
        queue_file(2, 2, 26, 1'b0, 1'b0, 0);
        queue_file(3, 1, 30, 1'b1, 1'b0, 3);
        queue_file(0, 5, 26, 1'b1, 1'b0, 4);
        queue_file(32'hFFFF_FFFF, 1, 26, 1'b1, 1'b0, 2);
        queue_file(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 0);
        queue_file(4, 2, 25, 1'b1, 1'b0, 3);
        queue_file(65, 64, 0, 1'b1, 1'b0, 1);
        queue_file(64, 1, 26, 1'b1, 1'b0, -160);
        queue_file(1, 64, 26, 1'b1, 1'b1, -230);
        // Only the start of the bottom row: reaches the top address bits.
        queue_file(64, 64, 27, 1'b1, 1'b0, 31 - (1 + 64 * 64 * 3));
        queue_file(2, 2, 32'hFFFF_FFFF, 1'b1, 1'b0, 6);
        queue_file(5, 3, 26, 1'b1, 1'b0, 5);
        directed_len = file_bytes.size();

        while (file_bytes.size() < directed_len + RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            w = small_dim();
            h = small_dim();
            if (kind < 70)
            begin
                queue_file(w, h, 26 + $urandom_range(0, 4), 1'b1,
                           $urandom_range(0, 7) == 0,
                           $urandom_range(0, 1) ? 0 : $urandom_range(0, 4));
            end
            else if (kind < 78)
            begin
                queue_file(w, h, 26 + $urandom_range(0, 2), 1'b1, 1'b0,
                           -int'($urandom_range(1, 12)));
            end
            else if (kind < 85)
            begin
                if ($urandom_range(0, 1))
                    w = bad_dim();
                else
                    h = bad_dim();
                queue_file(w, h, $urandom(), 1'b1, 1'b0, $urandom_range(0, 5));
            end
            else if (kind < 92)
            begin
                queue_file(w, h, $urandom_range(0, 25), 1'b1, 1'b0, $urandom_range(0, 5));
            end
            else if (kind < 96)
            begin
                queue_file(w, h, 26 + $urandom_range(0, 2), 1'b0, 1'b0, 0);
            end
            else if (kind < 98)
            begin
                queue_file(w, h, $urandom() | 32'h0001_0000, 1'b1, 1'b0,
                           $urandom_range(1, 8));
            end
            else
            begin
                noise = $urandom_range(1, 10);
                for (int k = 0; k < noise; k++)
                begin
                    item.beat.file_byte = 8'($urandom());
                    item.beat.start_of_file = 1'b0;
                    item.drain_first = 1'b0;
                    file_bytes.push_back(item);
                end
            end
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (file_bytes.size() != 0 || byte_valid)
            @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors_found == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
